>>> hdl/tufp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tufp_pkg
// shared types, codes and widths of the telemetry upload flush policy block
// ----------------------------------------------------------------------------
package tufp_pkg;

  localparam int NUM_CHANNELS_DEF = 16;

  localparam int OP_W    = 3;
  localparam int CHAN_W  = 4;
  localparam int VALUE_W = 32;
  localparam int TICK_W  = 48;
  localparam int COUNT_W = 16;
  localparam int MODE_W  = 2;
  localparam int DB_W    = 32;
  localparam int IVL_W   = 32;
  localparam int LIMIT_W = 16;

  localparam logic [OP_W-1:0] OP_CONFIGURE = 3'd0;
  localparam logic [OP_W-1:0] OP_SAMPLE    = 3'd1;
  localparam logic [OP_W-1:0] OP_QUERY     = 3'd2;
  localparam logic [OP_W-1:0] OP_MARK      = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR     = 3'd4;

  localparam logic [MODE_W-1:0] MODE_REALTIME = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CHANGE   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_BATCH    = 2'd2;

  // per-channel settings and upload history, one memory word
  typedef struct packed {
    logic                      remote;
    logic [MODE_W-1:0]         mode;
    logic [DB_W-1:0]           deadband;
    logic [IVL_W-1:0]          interval;
    logic                      has_value;
    logic signed [VALUE_W-1:0] last_value;
  } entry_t;

endpackage

`default_nettype wire

>>> hdl/tufp_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tufp_in_if
// operation channel: valid/ready handshake with one operation per transaction
// ----------------------------------------------------------------------------
interface tufp_in_if import tufp_pkg::*; ();

  logic                      valid;
  logic                      ready;
  logic [OP_W-1:0]           operation;
  logic [CHAN_W-1:0]         channel;
  logic signed [VALUE_W-1:0] sample_value;
  logic [TICK_W-1:0]         now_ticks;
  logic [COUNT_W-1:0]        fill_level;
  logic                      cfg_remote;
  logic [MODE_W-1:0]         cfg_mode;
  logic [DB_W-1:0]           cfg_deadband;
  logic [IVL_W-1:0]          cfg_interval;

  modport source (
    output valid, operation, channel, sample_value, now_ticks, fill_level,
           cfg_remote, cfg_mode, cfg_deadband, cfg_interval,
    input  ready
  );

  modport sink (
    input  valid, operation, channel, sample_value, now_ticks, fill_level,
           cfg_remote, cfg_mode, cfg_deadband, cfg_interval,
    output ready
  );

endinterface

`default_nettype wire

>>> hdl/tufp_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tufp_out_if
// result channel: valid/ready handshake with flush answer and pending flags
// ----------------------------------------------------------------------------
interface tufp_out_if import tufp_pkg::*; ();

  logic valid;
  logic ready;
  logic flush_now;
  logic realtime_pending;
  logic change_pending;

  modport source (
    output valid, flush_now, realtime_pending, change_pending,
    input  ready
  );

  modport sink (
    input  valid, flush_now, realtime_pending, change_pending,
    output ready
  );

endinterface

`default_nettype wire

>>> hdl/tufp_entry_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tufp_entry_mem
// channel table: settings memory and flush time memory, one shared read
// address, registered read data, one write port on each memory
// ----------------------------------------------------------------------------
module tufp_entry_mem import tufp_pkg::*; #(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
  parameter int AW           = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
  input  wire logic              clk,
  input  wire logic [AW-1:0]     rd_addr,
  output      entry_t            rd_entry,
  output      logic [TICK_W-1:0] rd_flush,
  input  wire logic              ew_en,
  input  wire logic [AW-1:0]     ew_addr,
  input  wire entry_t            ew_data,
  input  wire logic              fw_en,
  input  wire logic [AW-1:0]     fw_addr,
  input  wire logic [TICK_W-1:0] fw_data
);

  entry_t            entry_mem [NUM_CHANNELS];
  logic [TICK_W-1:0] flush_mem [NUM_CHANNELS];

  always_ff @(posedge clk) begin
    if (ew_en) begin
      entry_mem[ew_addr] <= ew_data;
    end
    rd_entry <= entry_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (fw_en) begin
      flush_mem[fw_addr] <= fw_data;
    end
    rd_flush <= flush_mem[rd_addr];
  end

endmodule

`default_nettype wire

>>> hdl/telemetry_upload_flush_policy.sv
`default_nettype none
// ----------------------------------------------------------------------------
// telemetry_upload_flush_policy
// report-by-exception and batch flush policy over a table of telemetry
// channels held in memory
// ----------------------------------------------------------------------------
//  port       dir  kind           contents
//  in_chan    in   valid/ready    operation, channel, sample, time, count, setup
//  out_chan   out  valid/ready    flush_now, realtime_pending, change_pending
//  cfg_*      in   write enable   batch_limit
//
//  configure, clear and unknown operations pass dispatch then finish; a sample
//  also passes the sample step; a flush query that reaches the table scan and
//  mark-flushed both walk the table through its one read or write port, one
//  entry a cycle
//  rst_n is synchronous: channel valid bits, flags and batch_limit clear
//  one operation is in work at a time; a result waiting on out_chan holds the
//  next one at its last step, and a new operation is taken once it is handed over
// ----------------------------------------------------------------------------
module telemetry_upload_flush_policy import tufp_pkg::*; #(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  tufp_in_if.sink                 in_chan,
  tufp_out_if.source              out_chan,
  input  wire logic               cfg_we,
  input  wire logic [LIMIT_W-1:0] cfg_wdata
);

  localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int CW = $clog2(NUM_CHANNELS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SAMPLE,
    S_QUERY,
    S_MARK,
    S_FINISH
  } state_t;

  state_t                    state_r;
  logic [OP_W-1:0]           op_r;
  logic [CHAN_W-1:0]         chan_r;
  logic signed [VALUE_W-1:0] value_r;
  logic [TICK_W-1:0]         now_r;
  logic [COUNT_W-1:0]        count_r;
  logic                      remote_r;
  logic [MODE_W-1:0]         mode_r;
  logic [DB_W-1:0]           deadband_r;
  logic [IVL_W-1:0]          interval_r;
  logic [LIMIT_W-1:0]        batch_limit_r;
  logic [NUM_CHANNELS-1:0]   valid_r;
  logic                      pend_rt_r;
  logic                      pend_ch_r;
  logic                      flush_r;
  logic [CW-1:0]             idx_r;
  logic                      out_valid_r;
  logic                      out_flush_r;
  logic                      out_rt_r;
  logic                      out_ch_r;

  logic [AW-1:0]     ch_addr;
  logic              ch_ok;
  logic [AW-1:0]     scan_addr;
  logic [AW-1:0]     prev_addr;
  logic [AW-1:0]     rd_addr;
  entry_t            rd_entry;
  logic [TICK_W-1:0] rd_flush;
  logic              ew_en;
  logic [AW-1:0]     ew_addr;
  entry_t            ew_data;
  logic              fw_en;
  logic [AW-1:0]     fw_addr;
  logic [TICK_W-1:0] fw_data;

  logic signed [VALUE_W:0] diff;
  logic [VALUE_W:0]        mag;
  logic                    smp_live;
  logic                    smp_update;
  logic [TICK_W-1:0]       elapsed;
  logic                    batch_hit;
  logic                    limit_hit;
  logic                    out_free;

  assign ch_addr   = AW'(chan_r);
  assign ch_ok     = {{(32 - CHAN_W){1'b0}}, chan_r} < 32'(NUM_CHANNELS);
  assign scan_addr = idx_r[AW-1:0];
  assign prev_addr = AW'(idx_r - CW'(1));
  assign rd_addr   = (state_r == S_QUERY) ? scan_addr : ch_addr;

  // sample on a remote channel: realtime raises its flag, on-change compares
  // the magnitude of the step with the deadband
  assign smp_live   = ch_ok && valid_r[ch_addr] && rd_entry.remote;
  assign diff       = {value_r[VALUE_W-1], value_r}
                    - {rd_entry.last_value[VALUE_W-1], rd_entry.last_value};
  assign mag        = diff[VALUE_W] ? -diff : diff;
  assign smp_update = smp_live && (rd_entry.mode == MODE_CHANGE)
                    && (!rd_entry.has_value || (mag > {1'b0, rd_entry.deadband}));

  // scan data belongs to the entry addressed in the previous cycle
  assign elapsed   = now_r - rd_flush;
  assign batch_hit = (idx_r != '0) && valid_r[prev_addr] && rd_entry.remote
                   && (rd_entry.mode == MODE_BATCH) && (now_r >= rd_flush)
                   && (elapsed >= {{(TICK_W - IVL_W){1'b0}}, rd_entry.interval});

  assign limit_hit = (batch_limit_r != '0) && (count_r >= batch_limit_r);
  assign out_free  = !out_valid_r || out_chan.ready;

  always_comb begin
    ew_en   = 1'b0;
    ew_addr = ch_addr;
    ew_data = rd_entry;
    fw_en   = 1'b0;
    fw_addr = ch_addr;
    fw_data = now_r;
    unique case (state_r)
      S_DISPATCH: begin
        if (op_r == OP_CONFIGURE && ch_ok) begin
          ew_en               = 1'b1;
          ew_data.remote      = remote_r;
          ew_data.mode        = mode_r;
          ew_data.deadband    = deadband_r;
          ew_data.interval    = interval_r;
          ew_data.has_value   = 1'b0;
          ew_data.last_value  = '0;
          fw_en               = 1'b1;
        end
      end
      S_SAMPLE: begin
        ew_en              = smp_update;
        ew_data.has_value  = 1'b1;
        ew_data.last_value = value_r;
      end
      S_MARK: begin
        fw_en   = valid_r[scan_addr];
        fw_addr = scan_addr;
      end
      default: begin
      end
    endcase
  end

  tufp_entry_mem #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .AW           (AW)
  ) u_mem (
    .clk      (clk),
    .rd_addr  (rd_addr),
    .rd_entry (rd_entry),
    .rd_flush (rd_flush),
    .ew_en    (ew_en),
    .ew_addr  (ew_addr),
    .ew_data  (ew_data),
    .fw_en    (fw_en),
    .fw_addr  (fw_addr),
    .fw_data  (fw_data)
  );

  assign in_chan.ready             = (state_r == S_IDLE);
  assign out_chan.valid            = out_valid_r;
  assign out_chan.flush_now        = out_flush_r;
  assign out_chan.realtime_pending = out_rt_r;
  assign out_chan.change_pending   = out_ch_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      valid_r       <= '0;
      pend_rt_r     <= 1'b0;
      pend_ch_r     <= 1'b0;
      out_valid_r   <= 1'b0;
      batch_limit_r <= '0;
      idx_r         <= '0;
    end else begin
      if (cfg_we) begin
        batch_limit_r <= cfg_wdata;
      end
      // a new result may replace the one handed over at this edge
      if (state_r == S_FINISH && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_chan.valid) begin
            op_r       <= in_chan.operation;
            chan_r     <= in_chan.channel;
            value_r    <= in_chan.sample_value;
            now_r      <= in_chan.now_ticks;
            count_r    <= in_chan.fill_level;
            remote_r   <= in_chan.cfg_remote;
            mode_r     <= in_chan.cfg_mode;
            deadband_r <= in_chan.cfg_deadband;
            interval_r <= in_chan.cfg_interval;
            flush_r    <= 1'b0;
            idx_r      <= '0;
            state_r    <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          unique case (op_r)
            OP_CONFIGURE: begin
              if (ch_ok) begin
                valid_r[ch_addr] <= 1'b1;
              end
              state_r <= S_FINISH;
            end
            OP_SAMPLE: begin
              state_r <= S_SAMPLE;
            end
            OP_QUERY: begin
              priority if (count_r == '0) begin
                flush_r <= 1'b0;
                state_r <= S_FINISH;
              end else if (limit_hit || pend_rt_r || pend_ch_r) begin
                flush_r <= 1'b1;
                state_r <= S_FINISH;
              end else begin
                state_r <= S_QUERY;
              end
            end
            OP_MARK: begin
              pend_rt_r <= 1'b0;
              pend_ch_r <= 1'b0;
              state_r   <= S_MARK;
            end
            OP_CLEAR: begin
              valid_r   <= '0;
              pend_rt_r <= 1'b0;
              pend_ch_r <= 1'b0;
              state_r   <= S_FINISH;
            end
            default: begin
              state_r <= S_FINISH;
            end
          endcase
        end
        S_SAMPLE: begin
          if (smp_live && rd_entry.mode == MODE_REALTIME) begin
            pend_rt_r <= 1'b1;
          end
          if (smp_update) begin
            pend_ch_r <= 1'b1;
          end
          state_r <= S_FINISH;
        end
        S_QUERY: begin
          if (batch_hit) begin
            flush_r <= 1'b1;
          end
          if (idx_r == CW'(NUM_CHANNELS)) begin
            state_r <= S_FINISH;
          end else begin
            idx_r <= idx_r + CW'(1);
          end
        end
        S_MARK: begin
          if (idx_r == CW'(NUM_CHANNELS - 1)) begin
            state_r <= S_FINISH;
          end else begin
            idx_r <= idx_r + CW'(1);
          end
        end
        S_FINISH: begin
          if (out_free) begin
            out_flush_r <= flush_r;
            out_rt_r    <= pend_rt_r;
            out_ch_r    <= pend_ch_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
